// ----- src/dcan_pkg.sv -----
// shared constants, types and fixed-point helpers for the dilated convolution unit
package dcan_pkg;

  localparam int unsigned COEF_WORDS   = 4096;
  localparam int unsigned COEF_AW      = 12;
  localparam int unsigned LAYER_STRIDE = 160;
  localparam int unsigned HEAD_BASE    = 2560;

  // word offsets inside one layer block
  localparam int unsigned OFS_BIAS  = 135;
  localparam int unsigned OFS_MIX   = 138;
  localparam int unsigned OFS_RES_W = 141;
  localparam int unsigned OFS_RES_B = 150;
  localparam int unsigned OFS_DIL   = 153;
  localparam int unsigned OFS_KSEL  = 154;

  localparam int unsigned KERN_SHORT = 6;
  localparam int unsigned KERN_LONG  = 15;
  localparam logic signed [23:0] KSEL_SHORT = 24'sd6;

  // configuration register indexes
  localparam logic [2:0] CFG_LEAKY_SLOPE  = 3'd0;
  localparam logic [2:0] CFG_OUTPUT_SCALE = 3'd1;
  localparam logic [2:0] CFG_HEAD_BIAS    = 3'd2;
  localparam logic [2:0] CFG_GAIN_0       = 3'd3;
  localparam logic [2:0] CFG_GAIN_1       = 3'd4;
  localparam logic [2:0] CFG_GAIN_2       = 3'd5;

  localparam logic signed [31:0] ONE_Q23  = 32'sd8388608;
  localparam logic signed [63:0] RND_HALF = 64'sd262144;

  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } sat32_t;

  typedef struct packed {
    logic signed [23:0] value;
    logic               sat;
  } sat24_t;

  // one request for the shared multiply-accumulate unit
  typedef struct packed {
    logic               valid;
    logic               mem_a;
    logic signed [23:0] opa;
    logic               hist_b;
    logic [1:0]         hist_ch;
    logic signed [31:0] opb;
    logic [1:0]         dst;
  } mac_op_t;

  // round half up from 42 to 23 fraction bits, saturate to 32 bits
  function automatic sat32_t round_sat32(input logic signed [63:0] v);
    logic signed [63:0] t;
    logic signed [44:0] s;
    sat32_t r;
    t = v + RND_HALF;
    s = 45'(t >>> 19);
    r.sat = 1'b1;
    if (s > 45'sd2147483647) begin
      r.value = 32'sh7FFFFFFF;
    end else if (s < -45'sd2147483648) begin
      r.value = 32'sh80000000;
    end else begin
      r.value = 32'(s);
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  function automatic sat24_t round_sat24(input logic signed [63:0] v);
    logic signed [63:0] t;
    logic signed [44:0] s;
    sat24_t r;
    t = v + RND_HALF;
    s = 45'(t >>> 19);
    r.sat = 1'b1;
    if (s > 45'sd8388607) begin
      r.value = 24'sh7FFFFF;
    end else if (s < -45'sd8388608) begin
      r.value = 24'sh800000;
    end else begin
      r.value = 24'(s);
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  function automatic sat32_t add_sat32(input logic signed [31:0] a,
                                       input logic signed [31:0] b);
    logic signed [32:0] s;
    sat32_t r;
    s = 33'(a) + 33'(b);
    r.sat = 1'b1;
    if (s > 33'sd2147483647) begin
      r.value = 32'sh7FFFFFFF;
    end else if (s < -33'sd2147483648) begin
      r.value = 32'sh80000000;
    end else begin
      r.value = 32'(s);
      r.sat   = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- src/dilated_conv_audio_net_unit.sv -----
// dilated causal convolution stack with shared multiply-accumulate unit and sequencer
// the time per audio request grows with HEAD_TAPS and with the kernel K of each layer, and is set
// by the single multiply-accumulate unit, one product per cycle, and a 3-step modulo
// a coefficient write request is written straight from the input ports; one request is worked on at a time
// after reset a clearing pass zeroes both memories, and no request is taken until it ends
module dilated_conv_audio_net_unit #(
  parameter int unsigned NUM_LAYERS = 8,
  parameter int unsigned MAX_KERNEL = 15,
  parameter int unsigned HEAD_TAPS  = 16,
  parameter int unsigned HIST_DEPTH = 8192
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [11:0]        coef_addr_i,
  input  logic signed [23:0] coef_value_i,
  input  logic signed [23:0] sample_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] sample_out_o,
  output logic               saturated_o
);
  import dcan_pkg::*;

  localparam int unsigned HIST_WORDS = NUM_LAYERS * HIST_DEPTH;
  localparam int unsigned HAW        = $clog2(HIST_WORDS);
  localparam int unsigned PW         = $clog2(HIST_DEPTH);
  localparam int unsigned CLR_WORDS  = (HIST_WORDS > COEF_WORDS) ? HIST_WORDS : COEF_WORDS;
  localparam int unsigned CW         = $clog2(CLR_WORDS);
  localparam int unsigned LIW        = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
  localparam int unsigned HTW        = (HEAD_TAPS > 1) ? $clog2(HEAD_TAPS) : 1;
  localparam int unsigned KS_CAP     = (MAX_KERNEL < KERN_SHORT) ? MAX_KERNEL : KERN_SHORT;
  localparam int unsigned KL_CAP     = (MAX_KERNEL < KERN_LONG) ? MAX_KERNEL : KERN_LONG;
  localparam logic [3:0]  KS_M1      = 4'(KS_CAP - 1);
  localparam logic [3:0]  KL_M1      = 4'(KL_CAP - 1);
  localparam int unsigned MOD_STEPS  = 3;
  localparam int unsigned RECIP      = (1 << 24) / HIST_DEPTH;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_GAIN, S_DRAIN, S_LINRND, S_LRD, S_LDIL, S_LKERN, S_LMOD,
    S_LINIT, S_TAP, S_ACT, S_LEAKY, S_ACT2, S_RESB, S_RES, S_RESRND, S_HSHIFT,
    S_HEAD, S_Y, S_SCALE, S_FIN
  } state_e;

  state_e state_q, drain_next_q;

  logic signed [23:0] slope_q, scale_q, hbias_q;
  logic signed [23:0] gain_q [3];

  logic [CW-1:0]      clr_cnt_q;
  logic [2:0]         cnt_q;
  logic [1:0]         i_q, c_q;
  logic [LIW-1:0]     li_q;
  logic [11:0]        cbase_q, taddr_q, haddr_q;
  logic [HAW-1:0]     rbase_q;
  logic [PW-1:0]      ptr_q, off_q, dil_q;
  logic [23:0]        rem_q;
  logic [23:0]        quot_q;
  logic [4:0]         mstep_q;
  logic [3:0]         k_q;
  logic [HTW-1:0]     hk_q;
  logic signed [23:0] x_q;
  logic signed [31:0] lin_q [3];
  logic signed [31:0] act_q [3];
  logic signed [31:0] hs_q [3];
  logic [2:0]         neg_q;
  logic signed [31:0] yv_q;
  logic signed [63:0] acc_q [3];
  logic               sat_q;
  logic signed [31:0] head_q [HEAD_TAPS][3];

  mac_op_t            s1_q, iss;
  logic               s2_v_q;
  logic [1:0]         s2_dst_q;
  logic signed [55:0] prod_q;

  logic               out_valid_q, out_sat_q;
  logic signed [23:0] out_sample_q;

  logic [23:0]        coef_mem [COEF_WORDS];
  logic signed [23:0] coef_rd_q;
  logic               coef_we;
  logic [11:0]        coef_waddr, coef_raddr;
  logic [23:0]        coef_wdata;

  logic [95:0]        hist_mem [HIST_WORDS];
  logic [95:0]        hist_rd_q, hist_wdata;
  logic               hist_we, hist_re;
  logic [HAW-1:0]     hist_waddr, hist_raddr;

  logic [3:0]         j_idx;
  logic [PW:0]        idx_w, off_sum;
  logic [PW-1:0]      off_next;
  logic [44:0]        mod_prod;
  logic [23:0]        mod_back;
  logic [23:0]        rem_next;
  logic [3:0]         kern_m1;
  logic signed [23:0] mul_a;
  logic signed [31:0] mul_b;
  sat32_t             rs_c, rs_0, hs_add;
  sat24_t             o24;
  logic signed [31:0] act_new;
  logic               in_acc;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q   <= '0;
      scale_q   <= 24'sd524288;
      hbias_q   <= '0;
      gain_q[0] <= '0;
      gain_q[1] <= '0;
      gain_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEAKY_SLOPE:  slope_q   <= cfg_wdata_i;
        CFG_OUTPUT_SCALE: scale_q   <= cfg_wdata_i;
        CFG_HEAD_BIAS:    hbias_q   <= cfg_wdata_i;
        CFG_GAIN_0:       gain_q[0] <= cfg_wdata_i;
        CFG_GAIN_1:       gain_q[1] <= cfg_wdata_i;
        CFG_GAIN_2:       gain_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign saturated_o  = out_sat_q;

  // ---------------- address and helper logic ----------------
  assign j_idx = 4'(i_q) * 4'd3 + 4'(c_q);

  // tap lookback wraps inside the ring
  always_comb begin
    if (ptr_q >= off_q) begin
      idx_w = {1'b0, ptr_q} - {1'b0, off_q};
    end else begin
      idx_w = {1'b0, ptr_q} + (PW + 1)'(HIST_DEPTH) - {1'b0, off_q};
    end
    off_sum = {1'b0, off_q} + {1'b0, dil_q};
    if (off_sum >= (PW + 1)'(HIST_DEPTH)) begin
      off_next = PW'(off_sum - (PW + 1)'(HIST_DEPTH));
    end else begin
      off_next = PW'(off_sum);
    end
  end

  // dilation modulo the ring depth by reciprocal multiply, quotient at most one short
  assign mod_prod = 45'(rem_q) * 45'(RECIP);
  assign mod_back = quot_q * 24'(HIST_DEPTH);
  assign rem_next = (rem_q >= 24'(HIST_DEPTH)) ? (rem_q - 24'(HIST_DEPTH)) : rem_q;
  assign kern_m1  = (coef_rd_q == KSEL_SHORT) ? KS_M1 : KL_M1;

  assign rs_c    = round_sat32(acc_q[c_q]);
  assign rs_0    = round_sat32(acc_q[0]);
  assign o24     = round_sat24(acc_q[0]);
  assign act_new = neg_q[c_q] ? rs_c.value : act_q[c_q];
  assign hs_add  = add_sat32(hs_q[c_q], act_new);

  always_comb begin
    iss        = '0;
    coef_raddr = taddr_q + 12'(j_idx);
    hist_re    = 1'b0;
    hist_raddr = rbase_q + HAW'(idx_w);
    case (state_q)
      S_GAIN: begin
        iss.valid = 1'b1;
        iss.opa   = gain_q[cnt_q[1:0]];
        iss.opb   = 32'(x_q);
        iss.dst   = cnt_q[1:0];
      end
      S_LRD:  coef_raddr = cbase_q + 12'(OFS_DIL);
      S_LDIL: coef_raddr = cbase_q + 12'(OFS_KSEL);
      S_LINIT: begin
        iss.valid = 1'b1;
        iss.mem_a = 1'b1;
        if (cnt_q < 3'd3) begin
          coef_raddr = cbase_q + 12'(OFS_BIAS) + 12'(cnt_q);
          iss.opb    = ONE_Q23;
          iss.dst    = cnt_q[1:0];
        end else begin
          coef_raddr = cbase_q + 12'(OFS_MIX) + 12'(cnt_q - 3'd3);
          iss.opb    = 32'(x_q);
          iss.dst    = 2'(cnt_q - 3'd3);
        end
      end
      S_TAP: begin
        iss.valid   = 1'b1;
        iss.mem_a   = 1'b1;
        iss.hist_b  = 1'b1;
        iss.hist_ch = i_q;
        iss.dst     = c_q;
        hist_re     = (i_q == 2'd0) && (c_q == 2'd0);
      end
      S_LEAKY: begin
        iss.valid = neg_q[c_q];
        iss.opa   = slope_q;
        iss.opb   = act_q[c_q];
        iss.dst   = c_q;
      end
      S_RESB: begin
        iss.valid  = 1'b1;
        iss.mem_a  = 1'b1;
        coef_raddr = cbase_q + 12'(OFS_RES_B) + 12'(c_q);
        iss.opb    = ONE_Q23;
        iss.dst    = c_q;
      end
      S_RES: begin
        iss.valid  = 1'b1;
        iss.mem_a  = 1'b1;
        coef_raddr = cbase_q + 12'(OFS_RES_W) + 12'(j_idx);
        iss.opb    = act_q[i_q];
        iss.dst    = c_q;
      end
      S_HSHIFT: begin
        iss.valid = 1'b1;
        iss.opa   = hbias_q;
        iss.opb   = ONE_Q23;
      end
      S_HEAD: begin
        iss.valid  = 1'b1;
        iss.mem_a  = 1'b1;
        coef_raddr = haddr_q;
        iss.opb    = head_q[hk_q][c_q];
      end
      S_SCALE: begin
        iss.valid = 1'b1;
        iss.opa   = scale_q;
        iss.opb   = yv_q;
      end
      default: ;
    endcase
  end

  // ---------------- memories ----------------
  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = coef_addr_i;
    coef_wdata = coef_value_i;
    hist_we    = 1'b0;
    hist_waddr = rbase_q + HAW'(ptr_q);
    hist_wdata = {lin_q[2], lin_q[1], lin_q[0]};
    if (state_q == S_CLEAR) begin
      coef_we    = 1'b1;
      coef_waddr = clr_cnt_q[COEF_AW-1:0];
      coef_wdata = '0;
      hist_we    = ({1'b0, clr_cnt_q} < (CW + 1)'(HIST_WORDS));
      hist_waddr = clr_cnt_q[HAW-1:0];
      hist_wdata = '0;
    end else if (state_q == S_LRD) begin
      hist_we = 1'b1;
    end else if (in_acc && mode_i) begin
      coef_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_rd_q <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rd_q <= hist_mem[hist_raddr];
    end
  end

  // multiplier operands one stage after the request
  assign mul_a = s1_q.mem_a ? coef_rd_q : s1_q.opa;
  assign mul_b = s1_q.hist_b ? hist_rd_q[32*s1_q.hist_ch +: 32] : s1_q.opb;

  // ---------------- sequencer and datapath ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      drain_next_q <= S_IDLE;
      clr_cnt_q    <= '0;
      cnt_q        <= '0;
      i_q          <= '0;
      c_q          <= '0;
      li_q         <= '0;
      cbase_q      <= '0;
      taddr_q      <= '0;
      haddr_q      <= '0;
      rbase_q      <= '0;
      ptr_q        <= '0;
      off_q        <= '0;
      dil_q        <= '0;
      rem_q        <= '0;
      quot_q       <= '0;
      mstep_q      <= '0;
      k_q          <= '0;
      hk_q         <= '0;
      x_q          <= '0;
      neg_q        <= '0;
      yv_q         <= '0;
      sat_q        <= 1'b0;
      s1_q         <= '0;
      s2_v_q       <= 1'b0;
      s2_dst_q     <= '0;
      prod_q       <= '0;
      out_valid_q  <= 1'b0;
      out_sat_q    <= 1'b0;
      out_sample_q <= '0;
      for (int c = 0; c < 3; c++) begin
        lin_q[c] <= '0;
        act_q[c] <= '0;
        hs_q[c]  <= '0;
        acc_q[c] <= '0;
      end
      for (int t = 0; t < HEAD_TAPS; t++) begin
        for (int c = 0; c < 3; c++) begin
          head_q[t][c] <= '0;
        end
      end
    end else begin
      // multiply-accumulate pipeline
      s1_q     <= iss;
      s2_v_q   <= s1_q.valid;
      s2_dst_q <= s1_q.dst;
      prod_q   <= mul_a * mul_b;
      if (s2_v_q) begin
        acc_q[s2_dst_q] <= acc_q[s2_dst_q] + 64'(prod_q);
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == CW'(CLR_WORDS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && !mode_i) begin
            x_q   <= sample_in_i;
            sat_q <= 1'b0;
            cnt_q <= '0;
            for (int c = 0; c < 3; c++) begin
              hs_q[c]  <= '0;
              acc_q[c] <= '0;
            end
            state_q <= S_GAIN;
          end
        end
        S_GAIN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 3'd2) begin
            c_q          <= '0;
            drain_next_q <= S_LINRND;
            state_q      <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!s1_q.valid && !s2_v_q) begin
            state_q <= drain_next_q;
          end
        end
        S_LINRND: begin
          lin_q[c_q] <= rs_c.value;
          sat_q      <= sat_q | rs_c.sat;
          c_q        <= c_q + 1'b1;
          if (c_q == 2'd2) begin
            li_q    <= '0;
            cbase_q <= '0;
            rbase_q <= '0;
            state_q <= S_LRD;
          end
        end
        S_LRD: begin
          for (int c = 0; c < 3; c++) begin
            acc_q[c] <= '0;
          end
          state_q <= S_LDIL;
        end
        S_LDIL: begin
          rem_q   <= coef_rd_q;
          mstep_q <= 5'(MOD_STEPS - 1);
          state_q <= S_LKERN;
        end
        S_LKERN: begin
          k_q     <= kern_m1;
          taddr_q <= cbase_q + 12'(kern_m1) * 12'd9;
          state_q <= S_LMOD;
        end
        S_LMOD: begin
          mstep_q <= mstep_q - 1'b1;
          if (mstep_q == 5'd2) begin
            quot_q <= 24'(mod_prod[44:24]);
          end else if (mstep_q == 5'd1) begin
            rem_q <= rem_q - mod_back;
          end else begin
            dil_q   <= rem_next[PW-1:0];
            off_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_LINIT;
          end
        end
        S_LINIT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 3'd5) begin
            i_q     <= '0;
            c_q     <= '0;
            state_q <= S_TAP;
          end
        end
        S_TAP: begin
          // taps run from the current entry back to the oldest lookback
          if (c_q == 2'd2) begin
            c_q <= '0;
            i_q <= i_q + 1'b1;
            if (i_q == 2'd2) begin
              i_q <= '0;
              if (k_q == 4'd0) begin
                drain_next_q <= S_ACT;
                state_q      <= S_DRAIN;
              end else begin
                k_q     <= k_q - 1'b1;
                taddr_q <= taddr_q - 12'd9;
                off_q   <= off_next;
              end
            end
          end else begin
            c_q <= c_q + 1'b1;
          end
        end
        S_ACT: begin
          act_q[c_q] <= rs_c.value;
          neg_q[c_q] <= rs_c.value[31];
          sat_q      <= sat_q | rs_c.sat;
          acc_q[c_q] <= '0;
          c_q        <= c_q + 1'b1;
          if (c_q == 2'd2) begin
            c_q     <= '0;
            state_q <= S_LEAKY;
          end
        end
        S_LEAKY: begin
          c_q <= c_q + 1'b1;
          if (c_q == 2'd2) begin
            c_q          <= '0;
            drain_next_q <= S_ACT2;
            state_q      <= S_DRAIN;
          end
        end
        S_ACT2: begin
          act_q[c_q] <= act_new;
          hs_q[c_q]  <= hs_add.value;
          sat_q      <= sat_q | (neg_q[c_q] & rs_c.sat) | hs_add.sat;
          acc_q[c_q] <= 64'(lin_q[c_q]) <<< 19;
          c_q        <= c_q + 1'b1;
          if (c_q == 2'd2) begin
            c_q     <= '0;
            state_q <= S_RESB;
          end
        end
        S_RESB: begin
          c_q <= c_q + 1'b1;
          if (c_q == 2'd2) begin
            c_q     <= '0;
            i_q     <= '0;
            state_q <= S_RES;
          end
        end
        S_RES: begin
          if (c_q == 2'd2) begin
            c_q <= '0;
            i_q <= i_q + 1'b1;
            if (i_q == 2'd2) begin
              i_q          <= '0;
              drain_next_q <= S_RESRND;
              state_q      <= S_DRAIN;
            end
          end else begin
            c_q <= c_q + 1'b1;
          end
        end
        S_RESRND: begin
          lin_q[c_q] <= rs_c.value;
          sat_q      <= sat_q | rs_c.sat;
          c_q        <= c_q + 1'b1;
          if (c_q == 2'd2) begin
            c_q <= '0;
            if (li_q == LIW'(NUM_LAYERS - 1)) begin
              state_q <= S_HSHIFT;
            end else begin
              li_q    <= li_q + 1'b1;
              cbase_q <= cbase_q + 12'(LAYER_STRIDE);
              rbase_q <= rbase_q + HAW'(HIST_DEPTH);
              state_q <= S_LRD;
            end
          end
        end
        S_HSHIFT: begin
          for (int t = 0; t < HEAD_TAPS - 1; t++) begin
            for (int c = 0; c < 3; c++) begin
              head_q[t][c] <= head_q[t+1][c];
            end
          end
          for (int c = 0; c < 3; c++) begin
            head_q[HEAD_TAPS-1][c] <= hs_q[c];
          end
          acc_q[0] <= '0;
          haddr_q  <= 12'(HEAD_BASE);
          hk_q     <= '0;
          c_q      <= '0;
          state_q  <= S_HEAD;
        end
        S_HEAD: begin
          haddr_q <= haddr_q + 1'b1;
          if (c_q == 2'd2) begin
            c_q  <= '0;
            hk_q <= hk_q + 1'b1;
            if (hk_q == HTW'(HEAD_TAPS - 1)) begin
              drain_next_q <= S_Y;
              state_q      <= S_DRAIN;
            end
          end else begin
            c_q <= c_q + 1'b1;
          end
        end
        S_Y: begin
          yv_q     <= rs_0.value;
          sat_q    <= sat_q | rs_0.sat;
          acc_q[0] <= '0;
          state_q  <= S_SCALE;
        end
        S_SCALE: begin
          drain_next_q <= S_FIN;
          state_q      <= S_DRAIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_sample_q <= o24.value;
            out_sat_q    <= sat_q | o24.sat;
            ptr_q        <= (ptr_q == PW'(HIST_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_ready_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!s1_q.valid && !s2_v_q))
    else $error("request taken while the mac pipeline still holds work");

  a_hist_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_re |-> ({1'b0, hist_raddr} < (HAW + 1)'(HIST_WORDS)))
    else $error("history read beyond the ring storage");

  a_ring_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAP) |-> ({1'b0, ptr_q} < (PW + 1)'(HIST_DEPTH)
                            && {1'b0, off_q} < (PW + 1)'(HIST_DEPTH)
                            && {1'b0, dil_q} < (PW + 1)'(HIST_DEPTH)))
    else $error("ring pointer, offset or dilation out of range");

endmodule

// ----- test/tb.sv -----
// self-checking testbench for the dilated convolution audio unit: random requests, own predictor
module tb;
  import dcan_pkg::*;

  localparam int NL = 8;
  localparam int HD = 8192;
  localparam int HT = 16;
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int HOLD_CYCLES = 5000;

  typedef struct {
    bit                 mode;
    logic [11:0]        addr;
    logic signed [23:0] value;
    logic signed [23:0] sample;
  } req_t;

  typedef struct {
    logic signed [23:0] sample;
    bit                 sat;
  } audio_out_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [23:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               mode_i = 1'b0;
  logic [11:0]        coef_addr_i = '0;
  logic signed [23:0] coef_value_i = '0;
  logic signed [23:0] sample_in_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [23:0] sample_out_o;
  logic               saturated_o;

  dilated_conv_audio_net_unit i_dut (.*);

  // predictor state
  int                 layer_hist[NL*HD][3];
  int                 head_hist[HT][3];
  logic signed [23:0] coef_mem[COEF_WORDS];
  int unsigned        wr_ptr;
  logic signed [23:0] leaky_slope, out_scale, head_bias;
  logic signed [23:0] gain[3];
  bit                 clipped;

  req_t       pending_reqs[$];
  audio_out_t expected_samples[$];
  int         mismatches;
  int         idle_cycles;
  int         results_seen;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint rnd19(longint v);
    return (v + 64'sd262144) >>> 19;
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return 32'h80000000;
    end
    return int'(v);
  endfunction

  task automatic predict_request(req_t r);
    int lin[3], hs[3], act[3];
    longint acc[3], y, o, rs;
    int x, base, kern, off, idx, row;
    int unsigned dil;
    audio_out_t e;
    if (r.mode) begin
      coef_mem[r.addr] = r.value;
      return;
    end
    x = r.sample;
    clipped = 1'b0;
    hs = '{0, 0, 0};
    for (int c = 0; c < 3; c++) lin[c] = sat32(rnd19(longint'(gain[c]) * x));
    for (int li = 0; li < NL; li++) begin
      base = li * LAYER_STRIDE;
      row = li * HD;
      dil = coef_mem[base + OFS_DIL][12:0];
      kern = (coef_mem[base + OFS_KSEL] == KSEL_SHORT) ? KERN_SHORT : KERN_LONG;
      for (int c = 0; c < 3; c++) layer_hist[row + wr_ptr][c] = lin[c];
      for (int c = 0; c < 3; c++) begin
        acc[c] = longint'(coef_mem[base + OFS_BIAS + c]) * 8388608
               + longint'(coef_mem[base + OFS_MIX + c]) * x;
      end
      for (int k = 0; k < kern; k++) begin
        off = ((kern - 1 - k) * dil) % HD;
        idx = (wr_ptr + HD - off) % HD;
        for (int i = 0; i < 3; i++)
          for (int c = 0; c < 3; c++)
            acc[c] += longint'(coef_mem[base + k*9 + i*3 + c]) * layer_hist[row + idx][i];
      end
      for (int c = 0; c < 3; c++) begin
        act[c] = sat32(rnd19(acc[c]));
        if (act[c] < 0) act[c] = sat32(rnd19(longint'(act[c]) * leaky_slope));
        hs[c] = sat32(longint'(hs[c]) + act[c]);
      end
      for (int c = 0; c < 3; c++) begin
        rs = longint'(lin[c]) * 524288 + longint'(coef_mem[base + OFS_RES_B + c]) * 8388608;
        for (int i = 0; i < 3; i++)
          rs += longint'(coef_mem[base + OFS_RES_W + i*3 + c]) * act[i];
        lin[c] = sat32(rnd19(rs));
      end
    end
    for (int t = 0; t + 1 < HT; t++) head_hist[t] = head_hist[t + 1];
    for (int c = 0; c < 3; c++) head_hist[HT - 1][c] = hs[c];
    y = longint'(head_bias) * 8388608;
    for (int k = 0; k < HT; k++)
      for (int c = 0; c < 3; c++)
        y += longint'(coef_mem[HEAD_BASE + k*3 + c]) * head_hist[k][c];
    o = rnd19(longint'(sat32(rnd19(y))) * out_scale);
    if (o > 64'sd8388607) begin
      o = 8388607;
      clipped = 1'b1;
    end
    if (o < -64'sd8388608) begin
      o = -8388608;
      clipped = 1'b1;
    end
    wr_ptr = (wr_ptr + 1) % HD;
    e.sample = 24'(o);
    e.sat = clipped;
    expected_samples.push_back(e);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // driver
  int in_gap;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_request(pending_reqs.pop_front());
        in_gap = pick_gap();
      end
      if (in_valid_i && in_stall_o) begin
        // stalled request stays on the bus
      end else if (in_gap > 0 || pending_reqs.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i   <= 1'b1;
        mode_i       <= pending_reqs[0].mode;
        coef_addr_i  <= pending_reqs[0].addr;
        coef_value_i <= pending_reqs[0].value;
        sample_in_i  <= pending_reqs[0].sample;
      end
    end
  end

  // monitor and receiver stalls
  int out_gap;
  int hold_left;
  bit hold_done;
  always @(posedge clk_i) begin
    audio_out_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: sample %0d sat %0d", sample_out_o, saturated_o);
        end else begin
          e = expected_samples.pop_front();
          if (e.sample !== sample_out_o || e.sat !== saturated_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected sample %0d sat %0d, got sample %0d sat %0d",
                       e.sample, e.sat, sample_out_o, saturated_o);
          end
        end
      end
      if (!hold_done && results_seen == 10) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_gap = pick_gap();
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic signed [23:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_LEAKY_SLOPE:  leaky_slope = val;
      CFG_OUTPUT_SCALE: out_scale = val;
      CFG_HEAD_BIAS:    head_bias = val;
      CFG_GAIN_0:       gain[0] = val;
      CFG_GAIN_1:       gain[1] = val;
      CFG_GAIN_2:       gain[2] = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid_i || expected_samples.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic req_t coef_req(int addr, logic signed [23:0] val);
    req_t r;
    r.mode = 1'b1;
    r.addr = 12'(addr);
    r.value = val;
    r.sample = 24'($urandom);
    return r;
  endfunction

  function automatic req_t sample_req(logic signed [23:0] s);
    req_t r;
    r.mode = 1'b0;
    r.addr = 12'($urandom);
    r.value = 24'($urandom);
    r.sample = s;
    return r;
  endfunction

  function automatic logic signed [23:0] rand_weight();
    if ($urandom_range(0, 99) < 80) return 24'($urandom_range(0, 131071)) - 24'sd65536;
    return 24'($urandom);
  endfunction

  function automatic req_t rand_req();
    int r, li;
    r = $urandom_range(0, 99);
    li = $urandom_range(0, NL - 1);
    if (r < 62) return sample_req(24'($urandom));
    if (r < 78) return coef_req(li * LAYER_STRIDE + $urandom_range(0, OFS_RES_B + 2),
                                rand_weight());
    if (r < 84) begin
      if ($urandom_range(0, 3) == 0) return coef_req(li * LAYER_STRIDE + OFS_DIL, 24'($urandom));
      return coef_req(li * LAYER_STRIDE + OFS_DIL, 24'($urandom_range(0, 40)));
    end
    if (r < 89) begin
      if ($urandom_range(0, 3) == 0) return coef_req(li * LAYER_STRIDE + OFS_KSEL, 24'($urandom));
      return coef_req(li * LAYER_STRIDE + OFS_KSEL, KSEL_SHORT);
    end
    if (r < 95) return coef_req(HEAD_BASE + $urandom_range(0, 3*HT - 1), rand_weight());
    return coef_req($urandom_range(0, COEF_WORDS - 1), 24'($urandom));
  endfunction

  initial begin
    logic signed [23:0] v;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    foreach (layer_hist[i, c]) layer_hist[i][c] = 0;
    foreach (head_hist[i, c]) head_hist[i][c] = 0;
    wr_ptr = 0;
    leaky_slope = 0;
    out_scale = 24'sd524288;
    head_bias = 0;
    gain = '{0, 0, 0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_cfg(CFG_LEAKY_SLOPE, 24'sd262144);
    write_cfg(CFG_OUTPUT_SCALE, 24'sd524288);
    write_cfg(CFG_HEAD_BIAS, 24'sd1000);
    write_cfg(CFG_GAIN_0, 24'sd524288);
    write_cfg(CFG_GAIN_1, -24'sd262144);
    write_cfg(CFG_GAIN_2, 24'sd100000);
    write_cfg(3'd6, 24'sd12345);
    write_cfg(3'd7, -24'sd1);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;

    // short kernel with unit dilation, zero dilation, wrapping lookback, odd selector
    pending_reqs.push_back(coef_req(OFS_KSEL, KSEL_SHORT));
    pending_reqs.push_back(coef_req(OFS_DIL, 24'sd1));
    pending_reqs.push_back(coef_req(0, 24'sd300000));
    pending_reqs.push_back(coef_req(5*9 + 4, 24'sh7FFFFF));
    pending_reqs.push_back(coef_req(OFS_MIX, 24'sh800000));
    pending_reqs.push_back(coef_req(LAYER_STRIDE + OFS_DIL, 24'sd0));
    pending_reqs.push_back(coef_req(LAYER_STRIDE + 14*9, 24'sd200000));
    pending_reqs.push_back(coef_req(2*LAYER_STRIDE + OFS_DIL, 24'shFFFFFF));
    pending_reqs.push_back(coef_req(2*LAYER_STRIDE + 8, -24'sd150000));
    pending_reqs.push_back(coef_req(3*LAYER_STRIDE + OFS_KSEL, 24'sd7));
    pending_reqs.push_back(coef_req(3*LAYER_STRIDE + OFS_RES_W, 24'sd400000));
    pending_reqs.push_back(coef_req(NL*LAYER_STRIDE, 24'sh7FFFFF));
    pending_reqs.push_back(coef_req(COEF_WORDS - 1, 24'sh800000));
    pending_reqs.push_back(coef_req(HEAD_BASE + 3*(HT-1), 24'sd524288));
    pending_reqs.push_back(coef_req(HEAD_BASE + 1, -24'sd300000));
    pending_reqs.push_back(coef_req(HEAD_BASE + 3*(HT-1) + 2, 24'sh7FFFFF));
    pending_reqs.push_back(sample_req(24'sd0));
    pending_reqs.push_back(sample_req(24'sh7FFFFF));
    pending_reqs.push_back(sample_req(24'sh800000));
    pending_reqs.push_back(sample_req(-24'sd1));
    pending_reqs.push_back(sample_req(24'sd1));
    pending_reqs.push_back(sample_req(24'sh555555));
    pending_reqs.push_back(sample_req(24'shAAAAAA));
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      for (int idx = 0; idx < 8; idx++) begin
        case (ph)
          1: v = 24'sh7FFFFF;
          2: v = 24'sh800000;
          default: v = (idx == CFG_OUTPUT_SCALE) ? 24'($urandom_range(0, 1048575)) - 24'sd524288
                                                 : rand_weight();
        endcase
        write_cfg(3'(idx), v);
      end
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      repeat (45) pending_reqs.push_back(rand_req());
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
